[hdl/nccp_pkg.sv]
// Shared constants, types and segment tables for the coefficient compress/pack unit.
package nccp_pkg;

  localparam int unsigned MODULUS_Q = 7681;

  localparam int unsigned COEFF_W = 14;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned WID_W   = 4;
  localparam int unsigned CODE_W  = 11;
  localparam int unsigned F_W     = 10;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;
  localparam logic [WID_W-1:0] WID_9  = 4'd9;
  localparam logic [WID_W-1:0] WID_10 = 4'd10;
  localparam logic [WID_W-1:0] WID_11 = 4'd11;

  localparam int unsigned SEG_LOW    = 1024;
  localparam int unsigned SEG_LOW_SH = 10;
  localparam int unsigned SEG_MID    = 6144;

  // top segment divisor and its reciprocal; numerator stays below 2**N2_W
  localparam int unsigned SPAN   = (MODULUS_Q > SEG_MID) ? MODULUS_Q - SEG_MID : 1;
  localparam int unsigned SPAN_W = $clog2(SPAN + 1);
  localparam int unsigned HI_MAX = 410;
  localparam int unsigned N2_MAX = (SPAN - 1) * HI_MAX + SPAN / 2;
  localparam int unsigned N2_W   = $clog2(N2_MAX + 1);
  localparam int unsigned R2     = (1 << N2_W) / SPAN;
  localparam int unsigned R2_W   = $clog2(R2 + 1);

  // divide by 5 of the mid segment, exact below 16384
  localparam int unsigned DIV5_R = 13108;
  localparam int unsigned DIV5_S = 16;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [WID_W-1:0]  width;
  } nccp_entry_t;

  function automatic logic [WID_W-1:0] eff_width(logic [CFG_W-1:0] cfg);
    logic [WID_W-1:0] w;
    if (cfg < WID_9) begin
      w = WID_9;
    end else if (cfg > WID_11) begin
      w = WID_11;
    end else begin
      w = cfg;
    end
    return w;
  endfunction

  function automatic logic [F_W-1:0] seg_lo(logic [WID_W-1:0] w);
    logic [F_W-1:0] r;
    unique case (w)
      WID_9:   r = 10'd153;
      WID_10:  r = 10'd306;
      default: r = 10'd614;
    endcase
    return r;
  endfunction

  function automatic logic [F_W-1:0] seg_md(logic [WID_W-1:0] w);
    logic [F_W-1:0] r;
    unique case (w)
      WID_9:   r = 10'd255;
      WID_10:  r = 10'd511;
      default: r = 10'd1023;
    endcase
    return r;
  endfunction

  function automatic logic [F_W-1:0] seg_hi(logic [WID_W-1:0] w);
    logic [F_W-1:0] r;
    unique case (w)
      WID_9:   r = 10'd103;
      WID_10:  r = 10'd206;
      default: r = 10'd410;
    endcase
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] code_max(logic [WID_W-1:0] w);
    logic [CODE_W-1:0] r;
    unique case (w)
      WID_9:   r = 11'd511;
      WID_10:  r = 11'd1023;
      default: r = 11'd2047;
    endcase
    return r;
  endfunction

endpackage

[hdl/nccp_front.sv]
// Quantizer pipeline: lift, segment, scale and divide by constants, clamp.
module nccp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [nccp_pkg::CFG_W-1:0]   code_bits_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [nccp_pkg::COEFF_W-1:0] coeff_i,
  output logic                         push_o,
  output nccp_pkg::nccp_entry_t        push_data_o,
  input  logic                         full_i
);
  import nccp_pkg::*;

  typedef enum logic [1:0] {SEG_LO, SEG_MD, SEG_HI} seg_e;

  localparam int unsigned V_W    = $clog2((MODULUS_Q > 8192) ? MODULUS_Q : 8192);
  localparam int unsigned D_MAX  = (SPAN > 5120) ? SPAN : 5120;
  localparam int unsigned D_W    = $clog2(D_MAX);
  localparam int unsigned P_W    = D_W + F_W;
  localparam int unsigned N_W    = P_W + 1;
  localparam int unsigned OP_W   = (N2_W > 13) ? N2_W : 13;
  localparam int unsigned FAC_W  = (R2_W > 14) ? R2_W : 14;
  localparam int unsigned T_W    = OP_W + FAC_W;
  localparam int unsigned Q_W    = 10;
  localparam int unsigned M_W    = Q_W + SPAN_W;
  localparam int unsigned CMP_W  = ((OP_W > M_W) ? OP_W : M_W) + 1;
  localparam int unsigned SUM_W  = CODE_W + 1;

  logic adv;
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q;

  seg_e seg_a_q, seg_b_q, seg_c_q, seg_d_q, seg_e_q, seg_f_q;
  logic [WID_W-1:0] w_a_q, w_b_q, w_c_q, w_d_q, w_e_q, w_f_q;
  logic ovf_a_q, ovf_b_q, ovf_c_q, ovf_d_q, ovf_e_q, ovf_f_q;

  logic [V_W-1:0]   v_a_q;
  logic [P_W-1:0]   prod_b_q;
  logic [OP_W-1:0]  op_c_q, op_d_q, op_e_q, op_f_q;
  logic [T_W-1:0]   t_d_q;
  logic [Q_W-1:0]   q_e_q, q_f_q;
  logic [M_W-1:0]   m_f_q;

  // stage A inputs
  logic [16:0]      lifted;
  logic [V_W-1:0]   v_in;
  logic             ovf_in;
  seg_e             seg_in;

  // combinational per stage
  logic [D_W-1:0]   d_b;
  logic [F_W-1:0]   f_b;
  logic [N_W-1:0]   n_c;
  logic [OP_W-1:0]  op_c;
  logic [FAC_W-1:0] fac_d;
  logic [Q_W-1:0]   q_e;
  logic             fix_f;
  logic [CODE_W-1:0] base_f;
  logic [SUM_W-1:0] sum_f;
  logic [CODE_W-1:0] cmax_f;

  assign adv        = !vf_q || !full_i;
  assign in_ready_o = adv;
  assign push_o     = vf_q && !full_i;

  always_comb begin
    lifted = {{3{coeff_i[COEFF_W-1]}}, coeff_i} +
             (coeff_i[COEFF_W-1] ? 17'(MODULUS_Q) : 17'd0);
    v_in   = lifted[16] ? '0 : lifted[V_W-1:0];
    ovf_in = !lifted[16] && (lifted >= 17'(MODULUS_Q));
    if (v_in < V_W'(SEG_LOW)) begin
      seg_in = SEG_LO;
    end else if (v_in < V_W'(SEG_MID)) begin
      seg_in = SEG_MD;
    end else begin
      seg_in = SEG_HI;
    end
  end

  always_comb begin
    unique case (seg_a_q)
      SEG_LO: begin
        d_b = D_W'(v_a_q);
        f_b = seg_lo(w_a_q);
      end
      SEG_MD: begin
        d_b = D_W'(v_a_q - V_W'(SEG_LOW));
        f_b = seg_md(w_a_q);
      end
      default: begin
        d_b = D_W'(v_a_q - V_W'(SEG_MID));
        f_b = seg_hi(w_a_q);
      end
    endcase
  end

  always_comb begin
    unique case (seg_b_q)
      SEG_LO:  n_c = N_W'(prod_b_q) + N_W'(SEG_LOW - 1);
      SEG_MD:  n_c = N_W'(prod_b_q) + N_W'((SEG_MID - SEG_LOW) / 2);
      default: n_c = N_W'(prod_b_q) + N_W'(SPAN / 2);
    endcase
    // low segment is final after the shift, mid keeps a /5 to go
    op_c  = (seg_b_q == SEG_HI) ? OP_W'(n_c) : OP_W'(n_c >> SEG_LOW_SH);
    fac_d = (seg_c_q == SEG_MD) ? FAC_W'(DIV5_R) : FAC_W'(R2);
  end

  always_comb begin
    unique case (seg_d_q)
      SEG_LO:  q_e = Q_W'(op_d_q);
      SEG_MD:  q_e = Q_W'(t_d_q >> DIV5_S);
      default: q_e = Q_W'(t_d_q >> N2_W);
    endcase
  end

  always_comb begin
    // reciprocal estimate may be one low in the top segment
    fix_f  = (seg_f_q == SEG_HI) &&
             (CMP_W'(op_f_q) >= CMP_W'(m_f_q) + CMP_W'(SPAN));
    unique case (seg_f_q)
      SEG_LO:  base_f = '0;
      SEG_MD:  base_f = CODE_W'(seg_lo(w_f_q));
      default: base_f = CODE_W'(seg_lo(w_f_q)) + CODE_W'(seg_md(w_f_q));
    endcase
    sum_f  = SUM_W'(base_f) + SUM_W'(q_f_q) + SUM_W'(fix_f);
    cmax_f = code_max(w_f_q);
    push_data_o.width = w_f_q;
    push_data_o.code  = (ovf_f_q || (sum_f >= SUM_W'(cmax_f))) ? cmax_f : sum_f[CODE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_a_q    <= v_in;
      seg_a_q  <= seg_in;
      w_a_q    <= eff_width(code_bits_i);
      ovf_a_q  <= ovf_in;

      prod_b_q <= P_W'(d_b) * P_W'(f_b);
      seg_b_q  <= seg_a_q;
      w_b_q    <= w_a_q;
      ovf_b_q  <= ovf_a_q;

      op_c_q   <= op_c;
      seg_c_q  <= seg_b_q;
      w_c_q    <= w_b_q;
      ovf_c_q  <= ovf_b_q;

      t_d_q    <= T_W'(op_c_q) * T_W'(fac_d);
      op_d_q   <= op_c_q;
      seg_d_q  <= seg_c_q;
      w_d_q    <= w_c_q;
      ovf_d_q  <= ovf_c_q;

      q_e_q    <= q_e;
      op_e_q   <= op_d_q;
      seg_e_q  <= seg_d_q;
      w_e_q    <= w_d_q;
      ovf_e_q  <= ovf_d_q;

      m_f_q    <= M_W'(q_e_q) * M_W'(SPAN);
      q_f_q    <= q_e_q;
      op_f_q   <= op_e_q;
      seg_f_q  <= seg_e_q;
      w_f_q    <= w_e_q;
      ovf_f_q  <= ovf_e_q;
    end
  end

endmodule

[hdl/nccp_fifo.sv]
// Short code queue between the quantizer and the bit packer.
module nccp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  nccp_pkg::nccp_entry_t wdata_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output nccp_pkg::nccp_entry_t rdata_o,
  output logic                  empty_o
);
  import nccp_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  nccp_entry_t      mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hdl/nccp_back.sv]
// Bit packer: appends codes LSB first and emits one or two bytes per code.
module nccp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  nccp_pkg::nccp_entry_t entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);
  import nccp_pkg::*;

  localparam int unsigned ACC_W = CODE_W + 7;

  logic [6:0]       pend_q;
  logic [2:0]       cnt_q;
  logic             out_vld_q, out_last_q, sec_vld_q;
  logic [7:0]       out_byte_q, sec_q;

  logic             load;
  logic [ACC_W-1:0] acc;
  logic [4:0]       total;
  logic             two;

  assign load  = !out_vld_q || out_ready_i;
  assign pop_o = load && !sec_vld_q && !empty_i;

  always_comb begin
    acc   = ACC_W'(pend_q) | (ACC_W'(entry_i.code) << cnt_q);
    total = 5'(cnt_q) + 5'(entry_i.width);
    two   = (total >= 5'd16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      sec_vld_q  <= 1'b0;
      out_byte_q <= '0;
      sec_q      <= '0;
    end else if (load) begin
      if (sec_vld_q) begin
        out_vld_q  <= 1'b1;
        out_byte_q <= sec_q;
        out_last_q <= 1'b1;
        sec_vld_q  <= 1'b0;
      end else if (!empty_i) begin
        out_vld_q  <= 1'b1;
        out_byte_q <= acc[7:0];
        out_last_q <= !two;
        sec_vld_q  <= two;
        sec_q      <= acc[15:8];
        if (two) begin
          pend_q <= 7'(acc[ACC_W-1:16]);
          cnt_q  <= 3'(total - 5'd16);
        end else begin
          pend_q <= acc[14:8];
          cnt_q  <= 3'(total - 5'd8);
        end
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_sec_behind_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> (out_vld_q && !out_last_q))
    else $error("second byte held without a non-last first byte shown");
  a_two_sets_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && two) |=> sec_vld_q)
    else $error("two-byte code did not hold its second byte");
  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ready_i && !out_last_q) |=> (out_vld_q && out_last_q))
    else $error("last byte did not follow a non-last byte");
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pend_q >> cnt_q) == 7'd0))
    else $error("pending bits set above pending count");
`endif

endmodule

[hdl/nonuniform_coeff_compress_pack_unit.sv]
// Top level: config register, quantizer front, code queue and bit packer.
//
//  channel   direction  tdata / payload             handshake
//  s_axis    in         [13:0] coeff (signed)       tvalid/tready
//  m_axis    out        [7:0] out_byte, tlast=last  tvalid/tready
//  cfg       in         [3:0] code_bits             cfg_we_i, no wait
//
// The quantizer is a six-stage pipeline; a code then passes the queue and the
// packer's single output byte register, which sets the rate: one byte per cycle
// while codes wait and the output is ready, one or two bytes per coefficient.
// Reset returns code_bits to 10 and empties pipeline, queue and pending bits.
// Output stalls back up through the four-entry queue into the pipeline.
module nonuniform_coeff_compress_pack_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nccp_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,   // [13:0] coeff
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
  output logic                       m_axis_tlast
);
  import nccp_pkg::*;

  logic [CFG_W-1:0] code_bits_q;
  logic             push, full, pop, empty;
  nccp_entry_t      push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      code_bits_q <= cfg_wdata_i;
    end
  end

  nccp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .code_bits_i (code_bits_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .coeff_i     (s_axis_tdata[COEFF_W-1:0]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  nccp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_data),
    .empty_o (empty)
  );

  nccp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
